/* sv/sorted_key_list_engine_macros.svh */
// Assertion macros shared by the checker of the sorted key list engine.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SORTED_KEY_LIST_ENGINE_MACROS_SVH
`define SORTED_KEY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/skle_pkg.sv */
// Types and codes shared by the sorted key list engine and its cells.
// No dependencies.
package skle_pkg;

	localparam int KEY_W    = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int CNT_OUT_W = 7;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic [STATUS_W-1:0]     status_t;

	localparam cmd_t CMD_INSERT = 3'd0;
	localparam cmd_t CMD_DELETE = 3'd1;
	localparam cmd_t CMD_COUNT  = 3'd2;
	localparam cmd_t CMD_CLEAR  = 3'd3;
	localparam cmd_t CMD_READ   = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_RANGE     = 2'd3;

	// Broadcast from the control to every cell for the command in flight.
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		key_t             key;
		logic [POS_W-1:0] pos;
	} skle_ctl_t;

	// Per-cell compare results.
	typedef struct packed {
		logic ge;        // occupied and stored key >= command key
		logic first_eq;  // first occupied key >= command key, and equal to it
		logic match;     // occupied and equal to command key
	} skle_flags_t;

endpackage

/* sv/skle_cell.sv */
// One slot of the sorted key row: holds a key, compares it with the broadcast
// key and shifts left or right with its neighbors. Depends on skle_pkg.
module skle_cell
	import skle_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  skle_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  key_t          left_key,
	input  logic          left_ge,
	input  key_t          right_key,
	output key_t          key_o,
	output skle_flags_t   flags,
	output key_t          rd_key
);

	localparam int XW = (CW > POS_W) ? CW : POS_W;

	key_t key_q;
	logic occupied;
	logic at_count;
	logic selected;

	assign occupied = CW'(INDEX) < count;
	assign at_count = CW'(INDEX) == count;
	assign selected = occupied && (XW'(ctl.pos) == XW'(INDEX));

	assign flags.ge       = occupied && (key_q >= ctl.key);
	assign flags.match    = occupied && (key_q == ctl.key);
	assign flags.first_eq = flags.match && !left_ge;

	assign key_o  = key_q;
	assign rd_key = selected ? key_q : '0;

	// On insert, every cell past the insertion point takes its left
	// neighbor, and the cell at the insertion point takes the new key.
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (left_ge) begin
				key_q <= left_key;
			end else if (flags.ge || at_count) begin
				key_q <= ctl.key;
			end
		end else if (ctl.del_en && flags.ge) begin
			key_q <= right_key;
		end
	end

endmodule

/* sv/skle_popcount.sv */
// Balanced adder tree that counts the set bits of a vector.
// Depends on nothing.
module skle_popcount #(
	parameter int N = 64
) (
	input  logic [N-1:0]         bits,
	output logic [$clog2(N+1)-1:0] total
);

	localparam int OW = $clog2(N + 1);
	localparam int P  = 1 << $clog2(N);

	logic [OW-1:0] node [1:2*P-1];

	genvar g;
	generate
		for (g = 0; g < P; g++) begin : g_leaf
			if (g < N) begin : g_bit
				assign node[P+g] = {{(OW-1){1'b0}}, bits[g]};
			end else begin : g_pad
				assign node[P+g] = '0;
			end
		end
		for (g = 1; g < P; g++) begin : g_sum
			assign node[g] = node[2*g] + node[2*g+1];
		end
	endgenerate

	assign total = node[1];

endmodule

/* sv/sorted_key_list_engine.sv */
// Top level of the sorted key list engine: command register, row of key
// cells, status logic and result register. Depends on skle_pkg, skle_cell
// and skle_popcount.
//
// Channel   Direction  Handshake             Fields
// command   in         start, busy           command, key, position
// result    out        done (one-cycle)      status, match_count, entries_held, key_out
//
// A command is held in the command register while the cells compare and shift in
// parallel, then in the result register, where the result is shown while the match
// count runs through the adder tree. A new command is taken during the result cycle.
// The asynchronous reset empties the table; no clearing pass is needed.
// The receiver cannot stall: each result is shown on done for one cycle only.
module sorted_key_list_engine
	import skle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic signed [31:0]   key,
	input  logic [POS_W-1:0]     position,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [CNT_OUT_W-1:0] match_count,
	output logic [CNT_OUT_W-1:0] entries_held,
	output logic signed [31:0]   key_out
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic             valid_s1;
	cmd_t             cmd_s1;
	key_t             key_s1;
	logic [POS_W-1:0] pos_s1;

	logic                done_s2;
	status_t             status_s2;
	key_t                key_s2;
	logic [CAPACITY-1:0] match_s2;

	logic [CW-1:0] count_q;

	skle_ctl_t     ctl;
	key_t          cell_key [CAPACITY];
	key_t          cell_rd  [CAPACITY];
	skle_flags_t   cell_flags [CAPACITY];
	logic [CAPACITY-1:0] ge_v;
	logic [CAPACITY-1:0] first_v;
	logic [CAPACITY-1:0] match_v;

	logic    full;
	logic    found;
	logic    in_range;
	key_t    rd_any;
	status_t status_d;
	logic [CW-1:0] total;

	assign busy = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= command;
			key_s1 <= key;
			pos_s1 <= position;
		end
	end

	assign full     = count_q == CW'(CAPACITY);
	assign found    = |first_v;
	assign in_range = XW'(pos_s1) < XW'(count_q);

	assign ctl.ins_en = valid_s1 && (cmd_s1 == CMD_INSERT) && !full;
	assign ctl.del_en = valid_s1 && (cmd_s1 == CMD_DELETE) && found;
	assign ctl.key    = key_s1;
	assign ctl.pos    = pos_s1;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			key_t left_key;
			logic left_ge;
			key_t right_key;

			if (g == 0) begin : g_head
				assign left_key = '0;
				assign left_ge  = 1'b0;
			end else begin : g_mid
				assign left_key = cell_key[g-1];
				assign left_ge  = ge_v[g-1];
			end
			if (g == CAPACITY - 1) begin : g_tail
				assign right_key = cell_key[g];
			end else begin : g_next
				assign right_key = cell_key[g+1];
			end

			skle_cell #(
				.INDEX(g),
				.CW   (CW)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.count    (count_q),
				.left_key (left_key),
				.left_ge  (left_ge),
				.right_key(right_key),
				.key_o    (cell_key[g]),
				.flags    (cell_flags[g]),
				.rd_key   (cell_rd[g])
			);

			assign ge_v[g]    = cell_flags[g].ge;
			assign first_v[g] = cell_flags[g].first_eq;
			assign match_v[g] = cell_flags[g].match;
		end
	endgenerate

	// At most one cell drives a nonzero read key.
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | cell_rd[i];
		end
	end

	always_comb begin
		unique case (cmd_s1)
			CMD_INSERT: status_d = full ? ST_FULL : ST_OK;
			CMD_DELETE: status_d = found ? ST_OK : ST_NOT_FOUND;
			CMD_READ:   status_d = in_range ? ST_OK : ST_RANGE;
			default:    status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (valid_s1) begin
			priority if (ctl.ins_en) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.del_en) begin
				count_q <= count_q - CW'(1);
			end else if (cmd_s1 == CMD_CLEAR) begin
				count_q <= '0;
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status_d;
			key_s2    <= ((cmd_s1 == CMD_READ) && in_range) ? rd_any : '0;
			match_s2  <= (cmd_s1 == CMD_COUNT) ? match_v : '0;
		end
	end

	skle_popcount #(
		.N(CAPACITY)
	) u_popcount (
		.bits (match_s2),
		.total(total)
	);

	assign done         = done_s2;
	assign status       = status_s2;
	assign match_count  = CNT_OUT_W'(total);
	assign entries_held = CNT_OUT_W'(count_q);
	assign key_out      = key_s2;

endmodule

/* sv/skle_checker.sv */
// Port-level assertions for the sorted key list engine, bound to the top.
// Depends on skle_pkg and sorted_key_list_engine_macros.svh.
`include "sorted_key_list_engine_macros.svh"

module skle_checker
	import skle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [STATUS_W-1:0]  status,
	input logic [CNT_OUT_W-1:0] entries_held,
	input logic signed [31:0]   key_out
);

	localparam int CAP_CHK = CAPACITY;

	// An accepted transaction raises busy, and busy is followed by a result shown while busy is low.
	`SKLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`SKLE_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy cycle not followed by a result")
	`SKLE_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	// A result with an error status returns a zero key.
	`SKLE_ASSERT_NOW(a_key_zero, done && (status != ST_OK), key_out == 0, "key returned with error status")
	`SKLE_ASSERT_NOW(a_full_count, done && (status == ST_FULL) && (CAP_CHK < 128), entries_held == CNT_OUT_W'(CAP_CHK), "full status with table not full")

endmodule

bind sorted_key_list_engine skle_checker #(.CAPACITY(CAPACITY)) u_skle_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_list_engine: drives insert, delete, count,
// clear and read commands and checks each result against a sorted table kept here.
// Depends on skle_pkg and the engine RTL.
module tb;
	import skle_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int DRAIN_LIMIT = 200;
	localparam int RANDOM_CMDS = 1300;

	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] match_count;
		logic [CNT_OUT_W-1:0] entries_held;
		key_t                 key_out;
	} table_result_t;

	typedef enum int {MODE_GROW, MODE_SHRINK, MODE_CHURN} traffic_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cmd_t                 command = CMD_INSERT;
	key_t                 key = '0;
	logic [POS_W-1:0]     position = '0;
	logic                 done;
	status_t              status;
	logic [CNT_OUT_W-1:0] match_count;
	logic [CNT_OUT_W-1:0] entries_held;
	key_t                 key_out;

	// Local copy of the sorted table.
	key_t                 table_keys[CAPACITY];
	int                   table_size = 0;
	table_result_t        pending_results[$];

	int error_count  = 0;
	int cmds_sent    = 0;
	int results_seen = 0;
	int full_hits    = 0;
	int range_hits   = 0;
	int missed_dels  = 0;
	int peak_size    = 0;

	sorted_key_list_engine #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key(key),
		.position(position),
		.done(done),
		.status(status),
		.match_count(match_count),
		.entries_held(entries_held),
		.key_out(key_out)
	);

	always #5 clk = ~clk;

	function automatic int first_slot_not_below(key_t k);
		int slot;
		slot = 0;
		while (slot < table_size && table_keys[slot] < k)
			slot++;
		return slot;
	endfunction

	// Applies one command to the local table and returns the result it must produce.
	function automatic table_result_t apply_to_table(cmd_t cmd, key_t k, logic [POS_W-1:0] pos);
		table_result_t r;
		int slot;
		int j;
		int hits;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_INSERT: begin
				if (table_size >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					slot = first_slot_not_below(k);
					for (j = table_size; j > slot; j--)
						table_keys[j] = table_keys[j-1];
					table_keys[slot] = k;
					table_size++;
				end
			end
			CMD_DELETE: begin
				slot = first_slot_not_below(k);
				if (slot < table_size && table_keys[slot] == k) begin
					for (j = slot; j + 1 < table_size; j++)
						table_keys[j] = table_keys[j+1];
					table_size--;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			CMD_COUNT: begin
				hits = 0;
				for (j = 0; j < table_size; j++)
					if (table_keys[j] == k)
						hits++;
				r.match_count = CNT_OUT_W'(hits);
			end
			CMD_CLEAR: begin
				table_size = 0;
			end
			CMD_READ: begin
				if (int'(pos) < table_size)
					r.key_out = table_keys[pos];
				else
					r.status = ST_RANGE;
			end
			default: begin
			end
		endcase
		r.entries_held = CNT_OUT_W'(table_size);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: MISMATCH on result %0d, %s: got %0h, expected %0h",
			$time, results_seen, what, got, want);
		error_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the command is accepted.
	task automatic send_command(cmd_t cmd, key_t k, logic [POS_W-1:0] pos);
		table_result_t want;
		start = 1'b1;
		command = cmd;
		key = k;
		position = pos;
		do
			@(posedge clk);
		while (busy);
		want = apply_to_table(cmd, k, pos);
		pending_results.push_back(want);
		cmds_sent++;
		if (want.status == ST_FULL)
			full_hits++;
		if (want.status == ST_RANGE)
			range_hits++;
		if (want.status == ST_NOT_FOUND)
			missed_dels++;
		if (table_size > peak_size)
			peak_size = table_size;
		@(negedge clk);
	endtask

	task automatic pause_sender(int cycles);
		start = 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		start = 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
	endtask

	// Keys already stored in up to 45 of 100 picks, so deletes and counts hit, plus a small
	// pool for duplicates, the extremes, and fully random patterns.
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && table_size > 0)
			return table_keys[$urandom_range(0, table_size - 1)];
		if (r < 75)
			return key_t'($urandom_range(0, 15)) - key_t'(8);
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return {1'b1, {(KEY_W-1){1'b0}}};
				1: return {1'b0, {(KEY_W-1){1'b1}}};
				2: return '0;
				default: return '1;
			endcase
		end
		return key_t'($urandom);
	endfunction

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with no command pending", status, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (match_count !== want.match_count)
					report_mismatch("match_count", match_count, want.match_count);
				if (entries_held !== want.entries_held)
					report_mismatch("entries_held", entries_held, want.entries_held);
				if (key_out !== want.key_out)
					report_mismatch("key_out", key_out, want.key_out);
			end
		end
	end

	task automatic test_empty_table();
		send_command(CMD_READ, '0, '0);
		send_command(CMD_READ, '0, '1);
		send_command(CMD_DELETE, '0, '0);
		send_command(CMD_COUNT, '1, '0);
		send_command(CMD_CLEAR, '0, '0);
		// Undefined command codes must leave the table alone.
		send_command(cmd_t'(CMD_READ + 1), '0, '0);
		wait_drained();
	endtask

	task automatic test_key_extremes();
		key_t kmin;
		key_t kmax;
		kmin = {1'b1, {(KEY_W-1){1'b0}}};
		kmax = {1'b0, {(KEY_W-1){1'b1}}};
		send_command(CMD_INSERT, kmax, '0);
		send_command(CMD_INSERT, kmin, '0);
		send_command(CMD_INSERT, '0, '0);
		send_command(CMD_INSERT, '1, '0);
		send_command(CMD_INSERT, '0, '0);
		send_command(CMD_INSERT, kmin, '0);
		send_command(CMD_COUNT, '0, '0);
		send_command(CMD_COUNT, kmax, '0);
		send_command(CMD_COUNT, key_t'(5), '0);
		send_command(CMD_READ, '0, POS_W'(0));
		send_command(CMD_READ, '0, POS_W'(3));
		send_command(CMD_READ, '0, POS_W'(5));
		send_command(CMD_READ, '0, POS_W'(6));
		send_command(CMD_DELETE, '0, '0);
		send_command(CMD_DELETE, kmax, '0);
		send_command(CMD_DELETE, kmax, '0);
		send_command(CMD_READ, '1, '1);
		send_command(cmd_t'(CMD_READ + 3), '1, '1);
		send_command(CMD_CLEAR, '1, '0);
		wait_drained();
	endtask

	task automatic test_table_full();
		while (table_size < CAPACITY)
			send_command(CMD_INSERT, pick_key(), '0);
		send_command(CMD_INSERT, pick_key(), '0);
		send_command(CMD_INSERT, '0, '0);
		send_command(CMD_READ, '0, '1);
		send_command(CMD_COUNT, table_keys[0], '0);
		send_command(CMD_DELETE, table_keys[CAPACITY-1], '0);
		send_command(CMD_INSERT, pick_key(), '0);
		send_command(CMD_CLEAR, '0, '0);
		wait_drained();
	endtask

	task automatic test_random_traffic(int total);
		traffic_mode_t mode;
		int phase_left;
		int burst_left;
		int sent;
		int r;
		bit no_gaps;
		cmd_t cmd;
		logic [POS_W-1:0] pos;
		phase_left = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		mode = MODE_GROW;
		for (sent = 0; sent < total; sent++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 120);
				mode = traffic_mode_t'($urandom_range(0, 2));
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			// Hold off once until the engine has handed back everything it owes.
			if (sent == total / 2)
				wait_drained();
			r = $urandom_range(0, 99);
			case (mode)
				MODE_GROW:   cmd = r < 55 ? CMD_INSERT : r < 65 ? CMD_DELETE :
				                   r < 78 ? CMD_COUNT : r < 97 ? CMD_READ : CMD_CLEAR;
				MODE_SHRINK: cmd = r < 15 ? CMD_INSERT : r < 60 ? CMD_DELETE :
				                   r < 72 ? CMD_COUNT : r < 97 ? CMD_READ : CMD_CLEAR;
				default:     cmd = r < 35 ? CMD_INSERT : r < 65 ? CMD_DELETE :
				                   r < 80 ? CMD_COUNT : r < 98 ? CMD_READ : CMD_CLEAR;
			endcase
			if (cmd == CMD_CLEAR && $urandom_range(0, 1) == 0)
				cmd = cmd_t'($urandom_range(CMD_READ + 1, 7));
			if (table_size > 0 && $urandom_range(0, 3) != 0)
				pos = POS_W'($urandom_range(0, table_size - 1));
			else
				pos = POS_W'($urandom_range(0, 63));
			send_command(cmd, pick_key(), pos);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if (!no_gaps && $urandom_range(0, 2) != 0)
					pause_sender($urandom_range(1, 12));
			end else begin
				burst_left--;
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_table();
		test_key_extremes();
		test_table_full();
		test_random_traffic(RANDOM_CMDS);
		wait_drained();
		repeat (10)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", pending_results.size(), 0);
		$display("Sent %0d commands and checked %0d results; peak table size %0d.",
			cmds_sent, results_seen, peak_size);
		$display("Status cases hit: %0d table full, %0d not found, %0d out of range.",
			full_hits, missed_dels, range_hits);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout: the engine stopped accepting or returning transactions.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sorted_key_list_engine.f */
+incdir+sv
sv/skle_pkg.sv
sv/skle_cell.sv
sv/skle_popcount.sv
sv/sorted_key_list_engine.sv
sv/skle_checker.sv
dv/tb.sv
